// ===== rtl/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants for the byte ring buffer
// Opcodes, status codes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH_DEFAULT  = 256;
    localparam int LEN_W          = 9;     // ring_length and fill_count
    localparam int DATA_W         = 8;
    localparam int OFFS_W         = 8;
    localparam int OP_W           = 2;
    localparam int STAT_W         = 2;
    localparam int S_TDATA_W      = 16;    // write_data, peek_offset
    localparam int M_TDATA_W      = 24;    // 21 bits of fields, zero padded
    localparam logic [LEN_W-1:0] RING_LEN_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_OFFS = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic execute;   // apply the operation, start the store read
        logic present;   // move the result into the output register
    } brb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register empty or draining this cycle
    } brb_sts_t;

endpackage

// ===== rtl/brb_ctrl.sv =====
// ----------------------------------------------------------------------------
// brb_ctrl: sequencing for the byte ring buffer
// Steps each transaction through capture, execute and result load.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output brb_pkg::brb_cmd_t cmd,
    input  brb_pkg::brb_sts_t sts
);
    import brb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.present = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD: begin
                // wait for room in the output register
                if (sts.out_free) begin
                    cmd.present = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/brb_dp.sv =====
// ----------------------------------------------------------------------------
// brb_dp: datapath of the byte ring buffer
// Byte store, ring indices, fill count, length register and result register.
// ----------------------------------------------------------------------------
module brb_dp #(
    parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  brb_pkg::brb_cmd_t             cmd,
    output brb_pkg::brb_sts_t             sts,
    input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [brb_pkg::OP_W-1:0]      s_tuser,
    input  logic                          cfg_wr_en,
    input  logic [brb_pkg::LEN_W-1:0]     cfg_wr_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > DEPTH) begin
            r = LEN_W'(DEPTH);
        end
        return r;
    endfunction

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] store_q_reg;

    logic [LEN_W-1:0]  len_reg;
    logic [AW-1:0]     wr_idx_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [LEN_W-1:0]  count_reg;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [OFFS_W-1:0] offs_reg;

    logic [STAT_W-1:0] res_stat_reg;
    logic              res_use_reg;
    logic              res_full_reg;
    logic              res_empty_reg;
    logic [LEN_W-1:0]  res_count_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [CW-1:0]     len_ext;
    logic [AW-1:0]     wr_idx_inc;
    logic [AW-1:0]     rd_idx_inc;
    logic [CW-1:0]     peek_sum;
    logic [CW-1:0]     peek_idx;
    logic              is_full;
    logic              is_empty;
    logic              offs_bad;
    logic              do_write;
    logic              do_pop;
    logic [AW-1:0]     rd_addr;
    logic [STAT_W-1:0] stat_next;
    logic              use_next;
    logic [LEN_W-1:0]  count_next;
    logic [DATA_W-1:0] rdata_out;

    assign len_ext  = CW'(len_reg);
    assign is_full  = (count_reg == len_reg);
    assign is_empty = (count_reg == '0);
    assign offs_bad = (LEN_W'(offs_reg) >= count_reg);

    assign wr_idx_inc = (CW'(wr_idx_reg) + CW'(1) == len_ext) ? '0 : wr_idx_reg + AW'(1);
    assign rd_idx_inc = (CW'(rd_idx_reg) + CW'(1) == len_ext) ? '0 : rd_idx_reg + AW'(1);

    // offset counted from the oldest entry, wrapped once at the ring length
    assign peek_sum = CW'(rd_idx_reg) + CW'(offs_reg);
    assign peek_idx = (peek_sum >= len_ext) ? peek_sum - len_ext : peek_sum;

    always_comb begin
        stat_next = STAT_OK;
        use_next  = 1'b0;
        do_write  = 1'b0;
        do_pop    = 1'b0;
        rd_addr   = rd_idx_reg;
        unique case (op_reg)
            OP_ADD: begin
                if (is_full) begin
                    stat_next = STAT_FULL;
                end else begin
                    do_write = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (is_empty) begin
                    stat_next = STAT_EMPTY;
                end else begin
                    do_pop   = 1'b1;
                    use_next = 1'b1;
                end
            end
            OP_PEEK: begin
                rd_addr = peek_idx[AW-1:0];
                if (is_empty) begin
                    stat_next = STAT_EMPTY;
                end else if (offs_bad) begin
                    stat_next = STAT_BAD_OFFS;
                end else begin
                    use_next = 1'b1;
                end
            end
            OP_NOP: begin
                stat_next = STAT_OK;
            end
            default: begin
                stat_next = STAT_OK;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (do_write) begin
            count_next = count_reg + LEN_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - LEN_W'(1);
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.execute && do_write) begin
            store_mem[wr_idx_reg] <= wdata_reg;
        end
        if (cmd.execute) begin
            store_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= clamp_len(RING_LEN_RESET);
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else if (cfg_wr_en) begin
            // a new length empties the ring
            len_reg    <= clamp_len(cfg_wr_data);
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
            if (do_write) begin
                wr_idx_reg <= wr_idx_inc;
            end
            if (do_pop) begin
                rd_idx_reg <= rd_idx_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser;
            wdata_reg <= s_tdata[DATA_W-1:0];
            offs_reg  <= s_tdata[DATA_W +: OFFS_W];
        end
        if (cmd.execute) begin
            res_stat_reg  <= stat_next;
            res_use_reg   <= use_next;
            res_full_reg  <= (count_next == len_reg);
            res_empty_reg <= (count_next == '0);
            res_count_reg <= count_next;
        end
    end

    assign rdata_out = res_use_reg ? store_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.present) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.present) begin
            m_tdata_reg <= {3'b000, res_count_reg, res_empty_reg, res_full_reg,
                            rdata_out, res_stat_reg};
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

endmodule

// ===== rtl/byte_ring_buffer_with_peek.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek: byte FIFO ring with peek access
// Top level: controller and datapath, plus interface checks.
// ----------------------------------------------------------------------------
// Usage
//   Input channel s_*: s_tuser carries the opcode (add, remove, peek, no-op);
//   s_tdata carries write_data and peek_offset. Every transaction yields one
//   result transaction on m_*: status, read_data, full and empty flags and
//   the fill count after the operation.
//   cfg_wr_en/cfg_wr_data write ring_length (clamped to 1..DEPTH) and empty
//   the ring; write it only while no transaction is in flight.
// Timing
//   An accepted transaction is executed in the next cycle (store access with
//   a registered read); the result then waits in the load state until the
//   output register is free and shows on m_tvalid from there. The controller
//   handles one transaction at a time, stepping it through the capture,
//   execute and load states before it accepts the next one.
//   While the receiver stalls, the next transaction is still accepted and
//   executed and then waits until the output register frees up.
// Reset
//   aresetn (synchronous, active low) empties the ring and sets ring_length
//   to 256, clamped to DEPTH. Store contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek #(
    parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] write_data, [15:8] peek_offset
    input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  logic [brb_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [9:2] read_data, [10] full_flag, [11] empty_flag,
    // [20:12] fill_count, [23:21] zero
    output logic [brb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [brb_pkg::LEN_W-1:0]     cfg_wr_data
);
    import brb_pkg::*;

    brb_cmd_t cmd;
    brb_sts_t sts;

    brb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    brb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // one transaction in flight: no acceptance right after another
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in flight");

    // failed operations return zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != STAT_OK)) |-> (m_tdata[9:2] == '0))
        else $error("read_data not zero on a failed operation");

    // empty flag agrees with the count, and the ring is never full and empty
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[11] == (m_tdata[20:12] == '0)) && !(m_tdata[10] && m_tdata[11])))
        else $error("inconsistent full/empty flags");

    // a result leaves the output register only through the handshake
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule
